/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the odometry RTL; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define DWO_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("odometry assertion failed");
// Condition must never be seen outside reset.
`define DWO_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("odometry forbidden condition");
`else
`define DWO_ASSERT(lbl, clk, rst_n, prop)
`define DWO_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* hw/rtl/dwo_pkg.sv */
// ----------------------------------------------------------------------------
// dwo_pkg
// Types and constants for the differential wheel odometry block.
// ----------------------------------------------------------------------------
package dwo_pkg;

  localparam int RPM_COUNT_BITS_DEF = 16;

  localparam int CLICK_W  = 9;   // signed distance counters
  localparam int TOTAL_W  = 8;
  localparam int SUM_W    = 10;  // left +/- right
  localparam int DIST_W   = 25;
  localparam int ANGLE_W  = 26;
  localparam int RPM_W    = 24;
  localparam int TRIG_W   = 8;
  localparam int SCALE_W  = 16;
  localparam int RSCALE_W = 8;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam int RPM_MAX = 8388607;
  localparam int RPM_MIN = -8388608;

  localparam logic [TRIG_W-1:0]   TRIGGER_RST = 8'd2;
  localparam logic [SCALE_W-1:0]  DIST_SCALE_RST = 16'd3430;
  localparam logic [SCALE_W-1:0]  ANGLE_SCALE_RST = 16'd394;
  localparam logic [RSCALE_W-1:0] RPM_SCALE_RST = 8'd10;

  localparam logic REQ_CLICK = 1'b0;
  localparam logic REQ_TICK  = 1'b1;
  localparam logic WHEEL_LEFT = 1'b0;
  localparam logic KIND_POSE = 1'b0;
  localparam logic KIND_RPM  = 1'b1;

  typedef enum logic [1:0] {
    REG_TRIGGER = 2'd0,
    REG_DIST    = 2'd1,
    REG_ANGLE   = 2'd2,
    REG_RPM     = 2'd3
  } reg_idx_e;

  // Work handed from the counter stage to the result stage.
  typedef struct packed {
    logic                    kind;
    logic signed [SUM_W-1:0] click_sum;
    logic signed [SUM_W-1:0] click_diff;
  } dwo_work_t;

endpackage

/* hw/rtl/dwo_result.sv */
// ----------------------------------------------------------------------------
// dwo_result
// Scaling multiplies, halving, rpm saturation and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dwo_result #(
  parameter int RPM_COUNT_BITS = dwo_pkg::RPM_COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             work_valid_i,
  output logic                             work_ready_o,
  input  dwo_pkg::dwo_work_t               work_i,
  input  logic signed [RPM_COUNT_BITS-1:0] left_period_i,
  input  logic signed [RPM_COUNT_BITS-1:0] right_period_i,
  input  logic [dwo_pkg::SCALE_W-1:0]      distance_scale_i,
  input  logic [dwo_pkg::SCALE_W-1:0]      angle_scale_i,
  input  logic [dwo_pkg::RSCALE_W-1:0]     rpm_scale_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             kind_o,
  output logic signed [dwo_pkg::DIST_W-1:0]  distance_o,
  output logic signed [dwo_pkg::ANGLE_W-1:0] angle_o,
  output logic signed [dwo_pkg::RPM_W-1:0]   left_rpm_o,
  output logic signed [dwo_pkg::RPM_W-1:0]   right_rpm_o
);
  import dwo_pkg::*;

  localparam int ProdW = SUM_W + SCALE_W + 1;
  localparam int RpmProdW = (RPM_COUNT_BITS + RSCALE_W + 1 > RPM_W + 1) ?
                            RPM_COUNT_BITS + RSCALE_W + 1 : RPM_W + 1;
  localparam logic signed [RpmProdW-1:0] RpmHi = RpmProdW'(RPM_MAX);
  localparam logic signed [RpmProdW-1:0] RpmLo = RpmProdW'(RPM_MIN);

  logic signed [ProdW-1:0]    dist_prod, dist_adj, ang_prod;
  logic signed [RpmProdW-1:0] lprod, rprod;
  logic signed [RPM_W-1:0]    lrpm, rrpm;
  logic                       load;

  logic                       out_valid_q;
  logic                       kind_q;
  logic signed [DIST_W-1:0]   distance_q, distance_d;
  logic signed [ANGLE_W-1:0]  angle_q, angle_d;
  logic signed [RPM_W-1:0]    left_rpm_q, left_rpm_d, right_rpm_q, right_rpm_d;

  assign work_ready_o = !out_valid_q || out_ready_i;
  assign load = work_valid_i && work_ready_o;

  assign dist_prod = work_i.click_sum * $signed({1'b0, distance_scale_i});
  assign ang_prod  = work_i.click_diff * $signed({1'b0, angle_scale_i});
  // halve rounding toward zero: bias negatives by one before the shift
  assign dist_adj  = dist_prod + $signed({{(ProdW-1){1'b0}}, dist_prod[ProdW-1]});

  assign lprod = left_period_i * $signed({1'b0, rpm_scale_i});
  assign rprod = right_period_i * $signed({1'b0, rpm_scale_i});

  always_comb begin
    if (lprod > RpmHi) begin
      lrpm = RpmHi[RPM_W-1:0];
    end else if (lprod < RpmLo) begin
      lrpm = RpmLo[RPM_W-1:0];
    end else begin
      lrpm = lprod[RPM_W-1:0];
    end
    if (rprod > RpmHi) begin
      rrpm = RpmHi[RPM_W-1:0];
    end else if (rprod < RpmLo) begin
      rrpm = RpmLo[RPM_W-1:0];
    end else begin
      rrpm = rprod[RPM_W-1:0];
    end
  end

  always_comb begin
    distance_d  = '0;
    angle_d     = '0;
    left_rpm_d  = '0;
    right_rpm_d = '0;
    if (work_i.kind == KIND_RPM) begin
      left_rpm_d  = lrpm;
      right_rpm_d = rrpm;
    end else begin
      distance_d = dist_adj[DIST_W:1];
      angle_d    = ang_prod[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q      <= work_i.kind;
      distance_q  <= distance_d;
      angle_q     <= angle_d;
      left_rpm_q  <= left_rpm_d;
      right_rpm_q <= right_rpm_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign distance_o  = distance_q;
  assign angle_o     = angle_q;
  assign left_rpm_o  = left_rpm_q;
  assign right_rpm_o = right_rpm_q;

  logic rpm_shown, pose_shown;
  assign rpm_shown  = out_valid_q && kind_q == KIND_RPM;
  assign pose_shown = out_valid_q && kind_q == KIND_POSE;

  `DWO_ASSERT(a_rpm_no_pose, clk_i, rst_ni, rpm_shown |-> (distance_q == '0 && angle_q == '0))
  `DWO_ASSERT(a_pose_no_rpm, clk_i, rst_ni, pose_shown |-> (left_rpm_q == '0 && right_rpm_q == '0))
  `DWO_ASSERT(a_load_shows, clk_i, rst_ni, load |=> out_valid_q)

endmodule

/* hw/rtl/differential_wheel_odometry.sv */
// ----------------------------------------------------------------------------
// differential_wheel_odometry
// Encoder click / sample tick counters producing pose updates and rpm reports.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  request  | in_valid_i/in_ready_o, req_type, wheel,   | in
//           | forward                                   |
//  result   | out_valid_o/out_ready_i, kind, distance,  | out
//           | angle, left_rpm, right_rpm                |
//  config   | APB psel/penable/pwrite/paddr/pwdata      | in/out
//
//  One beat per cycle in while in_ready_o is high; a result passes the work
//  register and then the result register before out_valid_o rises.
//  Counters update at acceptance; the work register then the result register
//  carry the multiplies.
//  Reset clears all counters and loads the default scales; no clearing pass.
//  A stalled result holds both stages; in_ready_o drops only when both are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module differential_wheel_odometry #(
  parameter int RPM_COUNT_BITS = dwo_pkg::RPM_COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dwo_pkg::APB_AW-1:0]   paddr,
  input  logic [dwo_pkg::APB_DW-1:0]   pwdata,
  output logic [dwo_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic                         wheel_i,
  input  logic                         forward_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         kind_o,
  output logic signed [dwo_pkg::DIST_W-1:0]  distance_o,
  output logic signed [dwo_pkg::ANGLE_W-1:0] angle_o,
  output logic signed [dwo_pkg::RPM_W-1:0]   left_rpm_o,
  output logic signed [dwo_pkg::RPM_W-1:0]   right_rpm_o
);
  import dwo_pkg::*;

  localparam logic signed [RPM_COUNT_BITS-1:0] PerMax = {1'b0, {(RPM_COUNT_BITS-1){1'b1}}};
  localparam logic signed [RPM_COUNT_BITS-1:0] PerMin = {1'b1, {(RPM_COUNT_BITS-1){1'b0}}};

  // configuration
  logic [TRIG_W-1:0]   trigger_q;
  logic [SCALE_W-1:0]  dist_scale_q, angle_scale_q;
  logic [RSCALE_W-1:0] rpm_scale_q;
  logic                cfg_wr;
  reg_idx_e            reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q     <= TRIGGER_RST;
      dist_scale_q  <= DIST_SCALE_RST;
      angle_scale_q <= ANGLE_SCALE_RST;
      rpm_scale_q   <= RPM_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRIGGER: trigger_q     <= pwdata[TRIG_W-1:0];
        REG_DIST:    dist_scale_q  <= pwdata[SCALE_W-1:0];
        REG_ANGLE:   angle_scale_q <= pwdata[SCALE_W-1:0];
        REG_RPM:     rpm_scale_q   <= pwdata[RSCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRIGGER: prdata = {{(APB_DW-TRIG_W){1'b0}}, trigger_q};
      REG_DIST:    prdata = {{(APB_DW-SCALE_W){1'b0}}, dist_scale_q};
      REG_ANGLE:   prdata = {{(APB_DW-SCALE_W){1'b0}}, angle_scale_q};
      REG_RPM:     prdata = {{(APB_DW-RSCALE_W){1'b0}}, rpm_scale_q};
      default:     prdata = '0;
    endcase
  end

  // counters
  logic signed [CLICK_W-1:0]        left_q, left_d, right_q, right_d;
  logic signed [CLICK_W-1:0]        left_new, right_new, step;
  logic [TOTAL_W-1:0]               total_q, total_d, total_inc;
  logic signed [RPM_COUNT_BITS-1:0] lper_q, lper_d, rper_q, rper_d;
  logic signed [RPM_COUNT_BITS-1:0] lper_bump, rper_bump;

  // work stage
  logic                             work_valid_q, work_valid_d;
  dwo_work_t                        work_q, work_d;
  logic signed [RPM_COUNT_BITS-1:0] wlper_q, wlper_d, wrper_q, wrper_d;
  logic                             res_ready, in_fire, pose_fire;

  assign in_ready_o = !work_valid_q || res_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  assign step      = forward_i ? CLICK_W'(1) : {CLICK_W{1'b1}};
  assign left_new  = (wheel_i == WHEEL_LEFT) ? left_q + step : left_q;
  assign right_new = (wheel_i == WHEEL_LEFT) ? right_q : right_q + step;
  assign total_inc = total_q + TOTAL_W'(1);
  assign pose_fire = total_inc >= trigger_q;

  always_comb begin
    if (forward_i) begin
      lper_bump = (lper_q == PerMax) ? lper_q : lper_q + RPM_COUNT_BITS'(1);
      rper_bump = (rper_q == PerMax) ? rper_q : rper_q + RPM_COUNT_BITS'(1);
    end else begin
      lper_bump = (lper_q == PerMin) ? lper_q : lper_q - RPM_COUNT_BITS'(1);
      rper_bump = (rper_q == PerMin) ? rper_q : rper_q - RPM_COUNT_BITS'(1);
    end
  end

  always_comb begin
    left_d       = left_q;
    right_d      = right_q;
    total_d      = total_q;
    lper_d       = lper_q;
    rper_d       = rper_q;
    work_valid_d = work_valid_q && !res_ready;
    work_d       = work_q;
    wlper_d      = wlper_q;
    wrper_d      = wrper_q;
    if (in_fire) begin
      if (req_type_i == REQ_TICK) begin
        lper_d           = '0;
        rper_d           = '0;
        work_valid_d     = 1'b1;
        work_d.kind      = KIND_RPM;
        work_d.click_sum = '0;
        work_d.click_diff = '0;
        wlper_d          = lper_q;
        wrper_d          = rper_q;
      end else begin
        if (wheel_i == WHEEL_LEFT) begin
          lper_d = lper_bump;
        end else begin
          rper_d = rper_bump;
        end
        if (pose_fire) begin
          left_d            = '0;
          right_d           = '0;
          total_d           = '0;
          work_valid_d      = 1'b1;
          work_d.kind       = KIND_POSE;
          work_d.click_sum  = {left_new[CLICK_W-1], left_new} +
                              {right_new[CLICK_W-1], right_new};
          work_d.click_diff = {left_new[CLICK_W-1], left_new} -
                              {right_new[CLICK_W-1], right_new};
        end else begin
          left_d  = left_new;
          right_d = right_new;
          total_d = total_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      right_q      <= '0;
      total_q      <= '0;
      lper_q       <= '0;
      rper_q       <= '0;
      work_valid_q <= 1'b0;
    end else begin
      left_q       <= left_d;
      right_q      <= right_d;
      total_q      <= total_d;
      lper_q       <= lper_d;
      rper_q       <= rper_d;
      work_valid_q <= work_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    wlper_q <= wlper_d;
    wrper_q <= wrper_d;
  end

  dwo_result #(
    .RPM_COUNT_BITS(RPM_COUNT_BITS)
  ) u_result (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .work_valid_i     (work_valid_q),
    .work_ready_o     (res_ready),
    .work_i           (work_q),
    .left_period_i    (wlper_q),
    .right_period_i   (wrper_q),
    .distance_scale_i (dist_scale_q),
    .angle_scale_i    (angle_scale_q),
    .rpm_scale_i      (rpm_scale_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .distance_o       (distance_o),
    .angle_o          (angle_o),
    .left_rpm_o       (left_rpm_o),
    .right_rpm_o      (right_rpm_o)
  );

  logic tick_fire, pose_done, work_stall;
  assign tick_fire  = in_fire && req_type_i == REQ_TICK;
  assign pose_done  = in_fire && req_type_i == REQ_CLICK && pose_fire;
  assign work_stall = work_valid_q && !res_ready;

  `DWO_ASSERT(a_tick_clears, clk_i, rst_ni, tick_fire |=> (lper_q == '0 && rper_q == '0))
  `DWO_ASSERT(a_pose_clears, clk_i, rst_ni, pose_done |=> (total_q == '0 && left_q == '0))
  `DWO_ASSERT(a_work_holds, clk_i, rst_ni, work_stall |=> (work_valid_q && $stable(work_q)))
  `DWO_NEVER(a_click_range, clk_i, rst_ni, left_q == 9'h100 || right_q == 9'h100)

endmodule

/* tb/odometry_checker.sv */
// ----------------------------------------------------------------------------
// odometry_checker
// Watches the APB, request and result channels of the odometry block, keeps
// its own copy of the counters and registers, predicts every pose update and
// rpm report, and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module odometry_checker #(
  parameter int RPM_COUNT_BITS = dwo_pkg::RPM_COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [dwo_pkg::APB_AW-1:0]          paddr,
  input  logic [dwo_pkg::APB_DW-1:0]          pwdata,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic                                wheel_i,
  input  logic                                forward_i,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic                                kind_o,
  input  logic signed [dwo_pkg::DIST_W-1:0]   distance_o,
  input  logic signed [dwo_pkg::ANGLE_W-1:0]  angle_o,
  input  logic signed [dwo_pkg::RPM_W-1:0]    left_rpm_o,
  input  logic signed [dwo_pkg::RPM_W-1:0]    right_rpm_o,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import dwo_pkg::*;

  typedef struct packed {
    logic                      kind;
    logic signed [DIST_W-1:0]  distance;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [RPM_W-1:0]   left_rpm;
    logic signed [RPM_W-1:0]   right_rpm;
  } odo_result_t;

  localparam longint PERIOD_HI = (64'sd1 <<< (RPM_COUNT_BITS - 1)) - 1;
  localparam longint PERIOD_LO = -PERIOD_HI - 1;

  odo_result_t expected_q[$];

  logic [TRIG_W-1:0]                 trigger_cfg;
  logic [SCALE_W-1:0]                dist_scale_cfg;
  logic [SCALE_W-1:0]                angle_scale_cfg;
  logic [RSCALE_W-1:0]               rpm_scale_cfg;

  logic signed [CLICK_W-1:0]         left_dist_cnt;
  logic signed [CLICK_W-1:0]         right_dist_cnt;
  logic [TOTAL_W-1:0]                click_cnt;
  logic signed [RPM_COUNT_BITS-1:0]  left_period_cnt;
  logic signed [RPM_COUNT_BITS-1:0]  right_period_cnt;

  int fails = 0;

  assign fail_count_o = fails;

  // period counters clamp at the signed limits
  function automatic logic signed [RPM_COUNT_BITS-1:0] step_period(
      input logic signed [RPM_COUNT_BITS-1:0] cnt, input logic up);
    longint v;
    v = longint'(cnt);
    if (up) v = (v < PERIOD_HI) ? v + 1 : PERIOD_HI;
    else v = (v > PERIOD_LO) ? v - 1 : PERIOD_LO;
    return v[RPM_COUNT_BITS-1:0];
  endfunction

  function automatic logic signed [RPM_W-1:0] rpm_of_count(
      input logic signed [RPM_COUNT_BITS-1:0] cnt, input logic [RSCALE_W-1:0] scale);
    longint prod;
    prod = longint'(cnt) * longint'(scale);
    if (prod > RPM_MAX) prod = RPM_MAX;
    else if (prod < RPM_MIN) prod = RPM_MIN;
    return prod[RPM_W-1:0];
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  task automatic apply_write();
    case (reg_idx_e'(paddr[APB_AW-1:2]))
      REG_TRIGGER: trigger_cfg = pwdata[TRIG_W-1:0];
      REG_DIST:    dist_scale_cfg = pwdata[SCALE_W-1:0];
      REG_ANGLE:   angle_scale_cfg = pwdata[SCALE_W-1:0];
      REG_RPM:     rpm_scale_cfg = pwdata[RSCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_beat(input logic req, input logic side, input logic fwd);
    odo_result_t res;
    longint sum;
    longint diff;
    res = '0;
    if (req == REQ_TICK) begin
      res.kind = KIND_RPM;
      res.left_rpm = rpm_of_count(left_period_cnt, rpm_scale_cfg);
      res.right_rpm = rpm_of_count(right_period_cnt, rpm_scale_cfg);
      left_period_cnt = '0;
      right_period_cnt = '0;
      expected_q.push_back(res);
    end else begin
      click_cnt = click_cnt + 1'b1;
      if (side == WHEEL_LEFT) begin
        if (fwd) left_dist_cnt = left_dist_cnt + CLICK_W'(1);
        else left_dist_cnt = left_dist_cnt - CLICK_W'(1);
        left_period_cnt = step_period(left_period_cnt, fwd);
      end else begin
        if (fwd) right_dist_cnt = right_dist_cnt + CLICK_W'(1);
        else right_dist_cnt = right_dist_cnt - CLICK_W'(1);
        right_period_cnt = step_period(right_period_cnt, fwd);
      end
      if (click_cnt >= trigger_cfg) begin
        sum = longint'(left_dist_cnt) + longint'(right_dist_cnt);
        diff = longint'(left_dist_cnt) - longint'(right_dist_cnt);
        // signed divide truncates toward zero
        sum = (sum * longint'(dist_scale_cfg)) / 2;
        diff = diff * longint'(angle_scale_cfg);
        res.kind = KIND_POSE;
        res.distance = sum[DIST_W-1:0];
        res.angle = diff[ANGLE_W-1:0];
        left_dist_cnt = '0;
        right_dist_cnt = '0;
        click_cnt = '0;
        expected_q.push_back(res);
      end
    end
  endtask

  task automatic check_result();
    odo_result_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result beat: kind %0b distance %0d angle %0d rpm %0d/%0d",
             kind_o, distance_o, angle_o, left_rpm_o, right_rpm_o);
      fails++;
    end else begin
      want = expected_q.pop_front();
      check_field("kind", {31'd0, want.kind}, {31'd0, kind_o});
      check_field("distance", want.distance, distance_o);
      check_field("angle", want.angle, angle_o);
      check_field("left_rpm", want.left_rpm, left_rpm_o);
      check_field("right_rpm", want.right_rpm, right_rpm_o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      trigger_cfg = TRIGGER_RST;
      dist_scale_cfg = DIST_SCALE_RST;
      angle_scale_cfg = ANGLE_SCALE_RST;
      rpm_scale_cfg = RPM_SCALE_RST;
      left_dist_cnt = '0;
      right_dist_cnt = '0;
      click_cnt = '0;
      left_period_cnt = '0;
      right_period_cnt = '0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) apply_write();
      if (out_valid_o && out_ready_i) check_result();
      if (in_valid_i && in_ready_o) predict_beat(req_type_i, wheel_i, forward_i);
      pending_o <= expected_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the differential wheel odometry block: directed
// clicks and ticks at the register extremes, steady one-direction runs on
// both wheels, then random phases with random register settings, bursty
// requests and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dwo_pkg::*;

  localparam logic WHEEL_RIGHT = !WHEEL_LEFT;
  localparam logic DIR_FWD = 1'b1;
  localparam logic DIR_REV = 1'b0;
  localparam int   RUN_PAIRS = 40;
  localparam int   PHASE_BEATS = 130;

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_TOGGLE
  } ready_mode_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_AW-1:0]         paddr = '0;
  logic [APB_DW-1:0]         pwdata = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic                      req_type_i = REQ_CLICK;
  logic                      wheel_i = WHEEL_LEFT;
  logic                      forward_i = DIR_FWD;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic                      kind_o;
  logic signed [DIST_W-1:0]  distance_o;
  logic signed [ANGLE_W-1:0] angle_o;
  logic signed [RPM_W-1:0]   left_rpm_o;
  logic signed [RPM_W-1:0]   right_rpm_o;

  int          odo_fails;
  int          odo_pending;
  int          beats_left = 0;
  ready_mode_e ready_mode = READY_ALWAYS;
  int unsigned mode_left = 0;

  differential_wheel_odometry uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .wheel_i     (wheel_i),
    .forward_i   (forward_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .distance_o  (distance_o),
    .angle_o     (angle_o),
    .left_rpm_o  (left_rpm_o),
    .right_rpm_o (right_rpm_o)
  );

  odometry_checker #(
    .RPM_COUNT_BITS (RPM_COUNT_BITS_DEF)
  ) odo_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .wheel_i      (wheel_i),
    .forward_i    (forward_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .distance_o   (distance_o),
    .angle_o      (angle_o),
    .left_rpm_o   (left_rpm_o),
    .right_rpm_o  (right_rpm_o),
    .fail_count_o (odo_fails),
    .pending_o    (odo_pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // result side back-pressure, switching pattern at random intervals
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(16, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready_i <= 1'b1;
      READY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready_i <= ($urandom_range(0, 5) == 0);
      default:      out_ready_i <= ~out_ready_i;
    endcase
  end

  task automatic write_reg(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input int trig, input int dscale, input int ascale,
                              input int rscale);
    write_reg(REG_TRIGGER, trig);
    write_reg(REG_DIST, dscale);
    write_reg(REG_ANGLE, ascale);
    write_reg(REG_RPM, rscale);
  endtask

  // one request beat; bursts of random length separated by random gaps
  task automatic send_beat(input logic req, input logic side, input logic fwd);
    int gap;
    if (beats_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      beats_left = $urandom_range(1, 48);
    end
    beats_left--;
    in_valid_i <= 1'b1;
    req_type_i <= req;
    wheel_i <= side;
    forward_i <= fwd;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off until every predicted result is out, then let the pipe drain
  task automatic settle();
    in_valid_i <= 1'b0;
    beats_left = 0;
    @(posedge clk_i);
    while (odo_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int pick_scale(input int top_val);
    case ($urandom_range(0, 4))
      0: return 0;
      1: return top_val;
      default: return $urandom_range(0, top_val);
    endcase
  endfunction

  initial begin
    int trig;
    int fwd_pct;
    logic req;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values, trigger of two
    send_beat(REQ_CLICK, WHEEL_LEFT, DIR_FWD);
    send_beat(REQ_CLICK, WHEEL_RIGHT, DIR_FWD);
    send_beat(REQ_TICK, WHEEL_LEFT, DIR_FWD);
    send_beat(REQ_CLICK, WHEEL_LEFT, DIR_REV);
    send_beat(REQ_CLICK, WHEEL_LEFT, DIR_REV);
    send_beat(REQ_TICK, WHEEL_RIGHT, DIR_REV);
    send_beat(REQ_CLICK, WHEEL_RIGHT, DIR_REV);
    send_beat(REQ_CLICK, WHEEL_LEFT, DIR_FWD);
    send_beat(REQ_TICK, WHEEL_LEFT, DIR_FWD);
    settle();

    // trigger zero: every click fires; odd negative product halves toward zero
    program_regs(0, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_beat(REQ_CLICK, WHEEL_RIGHT, DIR_FWD);
    send_beat(REQ_CLICK, WHEEL_LEFT, DIR_REV);
    send_beat(REQ_TICK, WHEEL_RIGHT, DIR_FWD);
    settle();

    program_regs(1, 0, 0, 0);
    send_beat(REQ_CLICK, WHEEL_LEFT, DIR_FWD);
    send_beat(REQ_TICK, WHEEL_LEFT, DIR_REV);
    settle();

    // lowering the trigger below the running total fires on the next click
    program_regs(255, DIST_SCALE_RST, ANGLE_SCALE_RST, RPM_SCALE_RST);
    for (int i = 0; i < 10; i++) begin
      send_beat(REQ_CLICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    settle();
    write_reg(REG_TRIGGER, 3);
    send_beat(REQ_CLICK, WHEEL_RIGHT, DIR_REV);
    settle();

    // largest distance either way
    program_regs(255, 16'hFFFF, 16'hFFFF, 8'hFF);
    for (int i = 0; i < 255; i++) send_beat(REQ_CLICK, WHEEL_LEFT, DIR_FWD);
    for (int i = 0; i < 255; i++) send_beat(REQ_CLICK, WHEEL_RIGHT, DIR_REV);
    send_beat(REQ_TICK, WHEEL_LEFT, DIR_FWD);

    // steady runs, left up and right down, then rpm reports
    for (int i = 0; i < RUN_PAIRS; i++) begin
      send_beat(REQ_CLICK, WHEEL_LEFT, DIR_FWD);
      send_beat(REQ_CLICK, WHEEL_RIGHT, DIR_REV);
    end
    send_beat(REQ_TICK, WHEEL_RIGHT, DIR_REV);
    send_beat(REQ_TICK, WHEEL_LEFT, DIR_FWD);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: trig = 1;
        1: trig = 255;
        default: begin
          case ($urandom_range(0, 7))
            0: trig = 0;
            1: trig = 255;
            default: trig = $urandom_range(1, 8);
          endcase
        end
      endcase
      program_regs(trig, pick_scale(16'hFFFF), pick_scale(16'hFFFF), pick_scale(8'hFF));
      fwd_pct = $urandom_range(0, 100);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        req = ($urandom_range(0, 7) == 0) ? REQ_TICK : REQ_CLICK;
        send_beat(req, 1'($urandom_range(0, 1)), ($urandom_range(0, 99) < fwd_pct));
      end
      settle();
    end

    repeat (16) @(posedge clk_i);
    if (odo_fails == 0 && odo_pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dwo_pkg.sv
hw/rtl/dwo_result.sv
hw/rtl/differential_wheel_odometry.sv
tb/odometry_checker.sv
tb/tb_top.sv
